/* rtl/core/ntmcs_pkg.sv */
// ----------------------------------------------------------------------------
// ntmcs_pkg
// Types and constants shared by the neighbour table cells and the top level.
// ----------------------------------------------------------------------------
package ntmcs_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned COST_W  = 8;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      STATUS_ADDED     = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] neighbor_address;
      logic [COST_W-1:0] gateway_cost;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  next_hop_address;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // offer travelling along the cell row
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [COST_W-1:0] cost;
      logic              dup;
      logic              placed;
      logic              has_min;
      logic [COST_W-1:0] min_cost;
      logic [ADDR_W-1:0] min_addr;
   } token_type;

endpackage

/* rtl/core/ntmcs_cell.sv */
// ----------------------------------------------------------------------------
// ntmcs_cell
// One table entry. Checks the passing offer for a duplicate address, takes it
// into the first empty entry and folds its own cost into the running minimum.
// ----------------------------------------------------------------------------
module ntmcs_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  ntmcs_pkg::token_type tok_in,
   output ntmcs_pkg::token_type tok_out
);
   import ntmcs_pkg::*;

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   token_type         tok_ff, tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      cost_in     = cost_ff;
      if (tok_in.valid) begin
         if (valid_ff) begin
            if (addr_ff == tok_in.addr) begin
               tok_in_next.dup = 1'b1;
            end
            if (!tok_in.has_min || (cost_ff < tok_in.min_cost)) begin
               tok_in_next.has_min  = 1'b1;
               tok_in_next.min_cost = cost_ff;
               tok_in_next.min_addr = addr_ff;
            end
         end else if (!tok_in.dup && !tok_in.placed) begin
            valid_in           = 1'b1;
            addr_in            = tok_in.addr;
            cost_in            = tok_in.cost;
            tok_in_next.placed = 1'b1;
            if (!tok_in.has_min || (tok_in.cost < tok_in.min_cost)) begin
               tok_in_next.has_min  = 1'b1;
               tok_in_next.min_cost = tok_in.cost;
               tok_in_next.min_addr = tok_in.addr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cost_ff <= cost_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* rtl/core/neighbor_table_min_cost_select.sv */
// ----------------------------------------------------------------------------
// neighbor_table_min_cost_select
// Neighbour table with lowest-cost next-hop selection.
//
// Each req word offers a neighbour address and its cost to the gateway. The
// offer walks the row of TABLE_DEPTH cells, one cell per cycle: every cell
// checks it against its stored address, the first empty cell takes it, and
// the lowest cost seen so far (earlier entry on a tie) rides along.
// One rsp word comes back per req word: status, next-hop address and count.
// The result is registered in the rsp register, or in the hold register while
// the output stalls; a new word is taken only once the offer has left the row.
// req_stall is high while an offer is in the row or a result waits in the
// hold register; a result still waiting in the rsp register does not block
// the next word. A stalled rsp word holds.
// Synchronous reset empties the table, clears the count and sets the next
// hop to zero; there is no clearing pass.
// ----------------------------------------------------------------------------
module neighbor_table_min_cost_select #(
   parameter int unsigned TABLE_DEPTH = ntmcs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ntmcs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ntmcs_pkg::rsp_type rsp_data
);
   import ntmcs_pkg::*;

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   token_type         tok [TABLE_DEPTH+1];
   logic              req_fire;
   logic              out_free;
   logic              inflight_ff, inflight_in;
   logic              hold_valid_ff, hold_valid_in;
   rsp_type           hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   rsp_type           result;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign req_stall = inflight_ff || hold_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      tok[0]          = '0;
      tok[0].valid    = req_fire;
      tok[0].addr     = req_data.neighbor_address;
      tok[0].cost     = req_data.gateway_cost;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ntmcs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      best_in  = best_ff;
      if (tok[TABLE_DEPTH].valid && tok[TABLE_DEPTH].placed) begin
         count_in = count_ff + CNT_W'(1);
         best_in  = tok[TABLE_DEPTH].min_addr;
      end
      count_wide = {{COUNT_W{1'b0}}, count_in};
      if (tok[TABLE_DEPTH].dup) begin
         result.status = STATUS_DUPLICATE;
      end else if (tok[TABLE_DEPTH].placed) begin
         result.status = STATUS_ADDED;
      end else begin
         result.status = STATUS_FULL;
      end
      result.next_hop_address = best_in;
      result.entry_count      = count_wide[COUNT_W-1:0];
   end

   always_comb begin
      inflight_in   = inflight_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (req_fire) begin
         inflight_in = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (tok[TABLE_DEPTH].valid) begin
         inflight_in = 1'b0;
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
         end else begin
            hold_valid_in = 1'b1;
            hold_in       = result;
         end
      end else if (hold_valid_ff && out_free) begin
         hold_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         inflight_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         best_ff       <= '0;
      end else begin
         inflight_ff   <= inflight_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         best_ff       <= best_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
